// ===== rtl/imm_pkg.sv =====
package imm_pkg;

   // Field and register widths
   localparam int FUNC_W    = 2;
   localparam int IDX_W     = 5;
   localparam int DATA_W    = 32;
   localparam int STATUS_W  = 2;
   localparam int CFG_W     = 6;
   localparam int CSR_IDX_W = 2;
   // Effective dimensions never exceed 64, so 7 bits hold them
   localparam int DIM_W     = 7;

   localparam int MAX_DIM_DEFAULT = 32;

   // Operation codes
   localparam logic [FUNC_W-1:0] FUNC_WRITE_A = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_WRITE_B = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ    = 2'd2;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_MISMATCH = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_ROWS_A = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COLS_A = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ROWS_B = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_COLS_B = 2'd3;

   localparam logic [CFG_W-1:0] CFG_RESET = 6'd1;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic accept;
      logic decode;
      logic run;
      logic finish;
   } ctrl_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic req_valid;
      logic go_run;
      logic last_issue;
      logic pipe_busy;
      logic rsp_free;
   } dp_status_type;

   // Clamp a dimension register to the store size
   function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_W-1:0] v,
                                                input int unsigned max_dim);
      logic [DIM_W-1:0] lim;
      lim = DIM_W'(max_dim);
      return (DIM_W'(v) > lim) ? lim : DIM_W'(v);
   endfunction

endpackage

// ===== rtl/imm_req_if.sv =====
interface imm_req_if;
   logic                                valid;
   logic                                ready;
   logic        [imm_pkg::FUNC_W-1:0]   func;
   logic        [imm_pkg::IDX_W-1:0]    row;
   logic        [imm_pkg::IDX_W-1:0]    col;
   logic signed [imm_pkg::DATA_W-1:0]   value;

   modport source (output valid, func, row, col, value, input ready);
   modport sink   (input valid, func, row, col, value, output ready);
endinterface

// ===== rtl/imm_rsp_if.sv =====
interface imm_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [imm_pkg::DATA_W-1:0]   product_value;
   logic        [imm_pkg::STATUS_W-1:0] status;

   modport source (output valid, product_value, status, input ready);
   modport sink   (input valid, product_value, status, output ready);
endinterface

// ===== rtl/imm_ram.sv =====
module imm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/imm_ctrl.sv =====
module imm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  imm_pkg::dp_status_type status,
   output imm_pkg::ctrl_cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_RUN,
      S_DRAIN,
      S_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (status.req_valid) state_in = S_DECODE;
         end
         S_DECODE: begin
            state_in = status.go_run ? S_RUN : S_FINISH;
         end
         S_RUN: begin
            if (status.last_issue) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            if (!status.pipe_busy) state_in = S_FINISH;
         end
         S_FINISH: begin
            if (status.rsp_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Decode commands from state
   always_comb begin
      cmd.accept = (state_ff == S_IDLE);
      cmd.decode = (state_ff == S_DECODE);
      cmd.run    = (state_ff == S_RUN);
      cmd.finish = (state_ff == S_FINISH) && status.rsp_free;
   end

endmodule

// ===== rtl/imm_datapath.sv =====
module imm_datapath #(
   parameter int MAX_DIM = imm_pkg::MAX_DIM_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [imm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [imm_pkg::CFG_W-1:0]       csr_write_data,
   imm_req_if.sink                         req_bus,
   imm_rsp_if.source                       rsp_bus,
   input  imm_pkg::ctrl_cmd_type           cmd,
   output imm_pkg::dp_status_type          status
);

   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int KW    = $clog2(MAX_DIM + 1);
   localparam int CW    = 2 * imm_pkg::DIM_W;
   localparam int DW    = imm_pkg::DATA_W;
   localparam int DMW   = imm_pkg::DIM_W;

   // Configuration registers
   logic [imm_pkg::CFG_W-1:0] rows_a_ff, rows_a_in;
   logic [imm_pkg::CFG_W-1:0] cols_a_ff, cols_a_in;
   logic [imm_pkg::CFG_W-1:0] rows_b_ff, rows_b_in;
   logic [imm_pkg::CFG_W-1:0] cols_b_ff, cols_b_in;

   // Latched item
   logic [imm_pkg::FUNC_W-1:0]   func_ff, func_in;
   logic [imm_pkg::IDX_W-1:0]    row_ff, row_in;
   logic [imm_pkg::IDX_W-1:0]    col_ff, col_in;
   logic [DW-1:0]                value_ff, value_in;
   logic [imm_pkg::STATUS_W-1:0] status_ff, status_in;

   // Multiply-accumulate pipeline
   logic [KW-1:0] k_ff, k_in;
   logic          v1_ff, v1_in;
   logic          v2_ff, v2_in;
   logic [DW-1:0] prod_ff, prod_in;
   logic [DW-1:0] acc_ff, acc_in;

   // Output register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0]                rsp_product_ff, rsp_product_in;
   logic [imm_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic [DMW-1:0] eff_rows_a, eff_cols_a, eff_rows_b, eff_cols_b;
   logic           wr_a_ok, wr_b_ok, rd_in_range, dim_match, load;
   logic [imm_pkg::STATUS_W-1:0] dec_status;
   logic [AW-1:0]  wr_addr, rd_addr_a, rd_addr_b;
   logic [DW-1:0]  rd_data_a, rd_data_b;
   logic           wr_en_a, wr_en_b;

   // Register writes
   always_comb begin
      rows_a_in = rows_a_ff;
      cols_a_in = cols_a_ff;
      rows_b_in = rows_b_ff;
      cols_b_in = cols_b_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            imm_pkg::REG_ROWS_A: rows_a_in = csr_write_data;
            imm_pkg::REG_COLS_A: cols_a_in = csr_write_data;
            imm_pkg::REG_ROWS_B: rows_b_in = csr_write_data;
            imm_pkg::REG_COLS_B: cols_b_in = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff <= imm_pkg::CFG_RESET;
         cols_a_ff <= imm_pkg::CFG_RESET;
         rows_b_ff <= imm_pkg::CFG_RESET;
         cols_b_ff <= imm_pkg::CFG_RESET;
      end else begin
         rows_a_ff <= rows_a_in;
         cols_a_ff <= cols_a_in;
         rows_b_ff <= rows_b_in;
         cols_b_ff <= cols_b_in;
      end
   end

   // Clamp dimensions and check indexes
   assign eff_rows_a  = imm_pkg::eff_dim(rows_a_ff, MAX_DIM);
   assign eff_cols_a  = imm_pkg::eff_dim(cols_a_ff, MAX_DIM);
   assign eff_rows_b  = imm_pkg::eff_dim(rows_b_ff, MAX_DIM);
   assign eff_cols_b  = imm_pkg::eff_dim(cols_b_ff, MAX_DIM);
   assign wr_a_ok     = (DMW'(row_ff) < eff_rows_a) && (DMW'(col_ff) < eff_cols_a);
   assign wr_b_ok     = (DMW'(row_ff) < eff_rows_b) && (DMW'(col_ff) < eff_cols_b);
   assign rd_in_range = (DMW'(row_ff) < eff_rows_a) && (DMW'(col_ff) < eff_cols_b);
   assign dim_match   = (cols_a_ff == rows_b_ff);

   // Decode the result status; mismatch takes priority over range
   always_comb begin
      unique case (func_ff)
         imm_pkg::FUNC_WRITE_A: dec_status = wr_a_ok ? imm_pkg::ST_OK : imm_pkg::ST_RANGE;
         imm_pkg::FUNC_WRITE_B: dec_status = wr_b_ok ? imm_pkg::ST_OK : imm_pkg::ST_RANGE;
         imm_pkg::FUNC_READ: begin
            priority if (!dim_match) dec_status = imm_pkg::ST_MISMATCH;
            else if (!rd_in_range)   dec_status = imm_pkg::ST_RANGE;
            else                     dec_status = imm_pkg::ST_OK;
         end
         default: dec_status = imm_pkg::ST_RANGE;
      endcase
   end

   // Latch the item on transfer
   assign load = req_bus.valid && cmd.accept;

   always_comb begin
      func_in   = func_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      value_in  = value_ff;
      status_in = status_ff;
      if (load) begin
         func_in  = req_bus.func;
         row_in   = req_bus.row;
         col_in   = req_bus.col;
         value_in = req_bus.value;
      end
      if (cmd.decode) status_in = dec_status;
   end

   always_ff @(posedge clock) begin
      func_ff   <= func_in;
      row_ff    <= row_in;
      col_ff    <= col_in;
      value_ff  <= value_in;
      status_ff <= status_in;
   end

   // Store addresses: row-major, MAX_DIM words per row
   assign wr_addr   = AW'(CW'(row_ff) * CW'(MAX_DIM) + CW'(col_ff));
   assign rd_addr_a = AW'(CW'(row_ff) * CW'(MAX_DIM) + CW'(k_ff));
   assign rd_addr_b = AW'(CW'(k_ff) * CW'(MAX_DIM) + CW'(col_ff));
   assign wr_en_a   = cmd.decode && (func_ff == imm_pkg::FUNC_WRITE_A) && wr_a_ok;
   assign wr_en_b   = cmd.decode && (func_ff == imm_pkg::FUNC_WRITE_B) && wr_b_ok;

   imm_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_ram_a (
      .clock   (clock),
      .wr_en   (wr_en_a),
      .wr_addr (wr_addr),
      .wr_data (value_ff),
      .rd_en   (cmd.run),
      .rd_addr (rd_addr_a),
      .rd_data (rd_data_a)
   );

   imm_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_ram_b (
      .clock   (clock),
      .wr_en   (wr_en_b),
      .wr_addr (wr_addr),
      .wr_data (value_ff),
      .rd_en   (cmd.run),
      .rd_addr (rd_addr_b),
      .rd_data (rd_data_b)
   );

   // Advance the inner index, multiply, accumulate
   always_comb begin
      k_in    = k_ff;
      acc_in  = acc_ff;
      v1_in   = cmd.run;
      v2_in   = v1_ff;
      prod_in = DW'(rd_data_a * rd_data_b);
      if (load) begin
         k_in   = '0;
         acc_in = '0;
      end else begin
         if (cmd.run) k_in = k_ff + KW'(1);
         if (v2_ff) acc_in = acc_ff + prod_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff    <= k_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
   end

   // Output register
   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_product_in = rsp_product_ff;
      rsp_status_in  = rsp_status_ff;
      if (cmd.finish) begin
         rsp_valid_in   = 1'b1;
         rsp_product_in = acc_ff;
         rsp_status_in  = status_ff;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_product_ff <= rsp_product_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign req_bus.ready         = cmd.accept;
   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.product_value = rsp_product_ff;
   assign rsp_bus.status        = rsp_status_ff;

   // Status to the controller
   always_comb begin
      status.req_valid  = req_bus.valid;
      status.go_run     = (func_ff == imm_pkg::FUNC_READ) && dim_match && rd_in_range
                          && (eff_cols_a != '0);
      status.last_issue = ((DMW'(k_ff) + DMW'(1)) == eff_cols_a);
      status.pipe_busy  = v1_ff || v2_ff;
      status.rsp_free   = !rsp_valid_ff || rsp_bus.ready;
   end

endmodule

// ===== rtl/integer_matrix_multiply.sv =====
// Integer matrix multiply: holds signed 32-bit matrices A and B in two
// MAX_DIM*MAX_DIM word memories and answers one request at a time with one
// response. A product read C[row][col] does one multiply-accumulate per inner
// index, over the effective inner dimension (cols_a clamped to MAX_DIM),
// through the single read port of each memory, followed by a short pipeline
// drain. A read with an empty inner dimension skips the multiply-accumulate
// and returns zero. Errors (dimension mismatch, index out of range, unused
// operation code) return with a zero product. The memories are not cleared:
// read only elements that have been written. Registers must be written
// through the csr_ port while no request is in flight; the block itself does
// not enforce this. A response waiting in the output register does not
// block the next request from being accepted, but that request then holds
// in its last step until the waiting response is taken.
module integer_matrix_multiply #(
   parameter int MAX_DIM = imm_pkg::MAX_DIM_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   imm_req_if.sink                       req_bus,
   imm_rsp_if.source                     rsp_bus,
   input  logic                          csr_write_enable,
   input  logic [imm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [imm_pkg::CFG_W-1:0]     csr_write_data
);

   imm_pkg::ctrl_cmd_type  cmd;
   imm_pkg::dp_status_type status;

   imm_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   imm_datapath #(.MAX_DIM(MAX_DIM)) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .cmd              (cmd),
      .status           (status)
   );

`ifndef ASSERT_OFF
   // One request at a time: no transfer in the cycle after a transfer
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !req_bus.ready)
      else $error("request accepted while another is in flight");

   // Error responses carry a zero product
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && (rsp_bus.status != imm_pkg::ST_OK)) |-> (rsp_bus.product_value == '0))
      else $error("error response with nonzero product");

   // Results are loaded only after the accumulate pipeline has drained
   a_drained: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !status.pipe_busy)
      else $error("result loaded while pipeline busy");

   // Status never carries the unused code
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.status == imm_pkg::ST_OK
                         || rsp_bus.status == imm_pkg::ST_MISMATCH
                         || rsp_bus.status == imm_pkg::ST_RANGE))
      else $error("invalid status code");
`endif

endmodule

// ===== tb/sv/integer_matrix_multiply_tb.sv =====
`timescale 1ns / 100ps

module integer_matrix_multiply_tb;
   import imm_pkg::*;

   localparam int DIM_LIMIT    = MAX_DIM_DEFAULT;
   localparam int STORE_WORDS  = DIM_LIMIT * DIM_LIMIT;
   localparam int NUM_PHASES   = 17;
   localparam int PHASE_ITEMS  = 75;
   localparam int HOLD_PHASE   = 8;
   localparam int PAUSE_PHASE  = 9;
   localparam int LONG_HOLD    = 400;
   localparam int SETTLE       = 4;
   localparam int DRAIN_CYCLES = 60;
   localparam int IDLE_HEAVY   = 70;
   localparam int IDLE_BOTH    = 29;
   localparam int MAX_REPORTS  = 200;

   // Operation code the block does not define
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   typedef struct packed {
      logic [FUNC_W-1:0]        func;
      logic [IDX_W-1:0]         row;
      logic [IDX_W-1:0]         col;
      logic signed [DATA_W-1:0] value;
   } mm_request_t;

   typedef struct packed {
      logic signed [DATA_W-1:0] product_value;
      logic [STATUS_W-1:0]      status;
   } mm_response_t;

   typedef enum logic [1:0] {
      STEP_SEND,
      STEP_SEND_FIXED,
      STEP_CSR
   } step_kind_t;

   typedef struct packed {
      step_kind_t           kind;
      logic [CSR_IDX_W-1:0] reg_index;
      logic [CFG_W-1:0]     reg_data;
      mm_request_t          request;
      mm_response_t         response;
   } directed_step_t;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_write_data;

   imm_req_if req_if ();
   imm_rsp_if rsp_if ();

   integer_matrix_multiply u_top (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_if),
      .rsp_bus          (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Matrix model: element stores, written flags and dimension registers
   logic signed [DATA_W-1:0] a_elems [STORE_WORDS];
   logic signed [DATA_W-1:0] b_elems [STORE_WORDS];
   bit                       a_written [STORE_WORDS];
   bit                       b_written [STORE_WORDS];
   logic [CFG_W-1:0]         dim_rows_a;
   logic [CFG_W-1:0]         dim_cols_a;
   logic [CFG_W-1:0]         dim_rows_b;
   logic [CFG_W-1:0]         dim_cols_b;

   mm_response_t pending_products [$];
   int           error_count;
   int           phase_count;
   int           sender_idle_pct;
   int           receiver_stall_pct;
   int           hold_cycles;

   // Directed stimulus: reset sizes first, then mismatch, empty inner and clamped sizes
   directed_step_t directed_steps [$] = '{
      '{STEP_SEND_FIXED, '0, '0, '{FUNC_WRITE_A, 5'd0, 5'd0, 32'h7FFF_FFFF}, '{32'sd0, ST_OK}},
      '{STEP_SEND_FIXED, '0, '0, '{FUNC_WRITE_B, 5'd0, 5'd0, 32'h8000_0000}, '{32'sd0, ST_OK}},
      '{STEP_SEND,       '0, '0, '{FUNC_READ,    5'd0, 5'd0, 32'h0000_0000}, '0},
      '{STEP_SEND_FIXED, '0, '0, '{FUNC_WRITE_A, 5'd1, 5'd0, 32'h0000_0001}, '{32'sd0, ST_RANGE}},
      '{STEP_SEND_FIXED, '0, '0, '{FUNC_WRITE_A, 5'd0, 5'd1, 32'h0000_0001}, '{32'sd0, ST_RANGE}},
      '{STEP_SEND_FIXED, '0, '0, '{FUNC_WRITE_B, 5'd31, 5'd31, 32'hFFFF_FFFF}, '{32'sd0, ST_RANGE}},
      '{STEP_SEND_FIXED, '0, '0, '{FUNC_UNUSED,  5'd31, 5'd31, 32'hFFFF_FFFF}, '{32'sd0, ST_RANGE}},
      '{STEP_SEND_FIXED, '0, '0, '{FUNC_READ,    5'd1, 5'd0, 32'h0000_0000}, '{32'sd0, ST_RANGE}},
      '{STEP_SEND_FIXED, '0, '0, '{FUNC_READ,    5'd0, 5'd31, 32'hFFFF_FFFF}, '{32'sd0, ST_RANGE}},
      '{STEP_SEND_FIXED, '0, '0, '{FUNC_WRITE_A, 5'd0, 5'd0, 32'hFFFF_FFFF}, '{32'sd0, ST_OK}},
      '{STEP_SEND_FIXED, '0, '0, '{FUNC_WRITE_B, 5'd0, 5'd0, 32'hFFFF_FFFF}, '{32'sd0, ST_OK}},
      '{STEP_SEND,       '0, '0, '{FUNC_READ,    5'd0, 5'd0, 32'h0000_0000}, '0},
      '{STEP_CSR, REG_COLS_A, 6'd2, '0, '0},
      '{STEP_SEND_FIXED, '0, '0, '{FUNC_READ,    5'd0, 5'd0, 32'h0000_0000}, '{32'sd0, ST_MISMATCH}},
      // raw sizes differ although both clamp to the store size
      '{STEP_CSR, REG_COLS_A, 6'd33, '0, '0},
      '{STEP_CSR, REG_ROWS_B, 6'd40, '0, '0},
      '{STEP_SEND_FIXED, '0, '0, '{FUNC_READ,    5'd0, 5'd0, 32'h0000_0000}, '{32'sd0, ST_MISMATCH}},
      // empty inner dimension
      '{STEP_CSR, REG_COLS_A, 6'd0, '0, '0},
      '{STEP_CSR, REG_ROWS_B, 6'd0, '0, '0},
      '{STEP_SEND_FIXED, '0, '0, '{FUNC_READ,    5'd0, 5'd0, 32'h7FFF_FFFF}, '{32'sd0, ST_OK}},
      '{STEP_SEND_FIXED, '0, '0, '{FUNC_WRITE_A, 5'd0, 5'd0, 32'h0000_0005}, '{32'sd0, ST_RANGE}},
      '{STEP_SEND_FIXED, '0, '0, '{FUNC_WRITE_B, 5'd0, 5'd0, 32'h0000_0005}, '{32'sd0, ST_RANGE}},
      // sizes above the store size act as the store size
      '{STEP_CSR, REG_ROWS_A, 6'd63, '0, '0},
      '{STEP_CSR, REG_COLS_A, 6'd1, '0, '0},
      '{STEP_CSR, REG_ROWS_B, 6'd1, '0, '0},
      '{STEP_CSR, REG_COLS_B, 6'd63, '0, '0},
      '{STEP_SEND_FIXED, '0, '0, '{FUNC_WRITE_A, 5'd31, 5'd0, 32'h8000_0000}, '{32'sd0, ST_OK}},
      '{STEP_SEND_FIXED, '0, '0, '{FUNC_WRITE_B, 5'd0, 5'd31, 32'h8000_0000}, '{32'sd0, ST_OK}},
      '{STEP_SEND,       '0, '0, '{FUNC_READ,    5'd31, 5'd31, 32'h0000_0000}, '0},
      '{STEP_SEND,       '0, '0, '{FUNC_READ,    5'd0, 5'd31, 32'h0000_0000}, '0},
      '{STEP_SEND,       '0, '0, '{FUNC_READ,    5'd31, 5'd0, 32'h0000_0000}, '0},
      '{STEP_SEND_FIXED, '0, '0, '{FUNC_WRITE_A, 5'd31, 5'd31, 32'h0000_0001}, '{32'sd0, ST_RANGE}}
   };

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int clamp_dim(input logic [CFG_W-1:0] v);
      return (int'(v) > DIM_LIMIT) ? DIM_LIMIT : int'(v);
   endfunction

   function automatic int store_addr(input int r, input int c);
      return r * DIM_LIMIT + c;
   endfunction

   // Apply one request to the matrix model and return the response it gives
   function automatic mm_response_t matrix_response(input mm_request_t rq);
      mm_response_t     rsp;
      logic [DATA_W-1:0] acc;
      int               r;
      int               c;
      rsp = '0;
      r   = int'(rq.row);
      c   = int'(rq.col);
      case (rq.func)
         FUNC_WRITE_A: begin
            if (r < clamp_dim(dim_rows_a) && c < clamp_dim(dim_cols_a)) begin
               a_elems[store_addr(r, c)]   = rq.value;
               a_written[store_addr(r, c)] = 1'b1;
            end else begin
               rsp.status = ST_RANGE;
            end
         end
         FUNC_WRITE_B: begin
            if (r < clamp_dim(dim_rows_b) && c < clamp_dim(dim_cols_b)) begin
               b_elems[store_addr(r, c)]   = rq.value;
               b_written[store_addr(r, c)] = 1'b1;
            end else begin
               rsp.status = ST_RANGE;
            end
         end
         FUNC_READ: begin
            // Mismatch compares raw register values and wins over the range check
            if (dim_cols_a != dim_rows_b) begin
               rsp.status = ST_MISMATCH;
            end else if (r >= clamp_dim(dim_rows_a) || c >= clamp_dim(dim_cols_b)) begin
               rsp.status = ST_RANGE;
            end else begin
               acc = '0;
               for (int k = 0; k < clamp_dim(dim_cols_a); k++) begin
                  acc = acc + a_elems[store_addr(r, k)] * b_elems[store_addr(k, c)];
               end
               rsp.product_value = acc;
            end
         end
         default: begin
            rsp.status = ST_RANGE;
         end
      endcase
      return rsp;
   endfunction

   function automatic logic signed [DATA_W-1:0] random_element();
      case ($urandom_range(9))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return '0;
         3:       return '1;
         4:       return DATA_W'($urandom_range(15)) - 32'sd8;
         default: return $urandom;
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      if (error_count < MAX_REPORTS) begin
         $display("%0t ns: mismatch: %s", $time, msg);
      end
      error_count++;
   endtask

   // Compare one response transfer with the oldest pending product
   task automatic check_response();
      mm_response_t want;
      if (pending_products.size() == 0) begin
         report_mismatch($sformatf("response with nothing pending (value %0d, status %0d)",
                                   rsp_if.product_value, rsp_if.status));
      end else begin
         want = pending_products.pop_front();
         if (rsp_if.product_value !== want.product_value) begin
            report_mismatch($sformatf("product_value %0d, want %0d",
                                      rsp_if.product_value, want.product_value));
         end
         if (rsp_if.status !== want.status) begin
            report_mismatch($sformatf("status %0d, want %0d", rsp_if.status, want.status));
         end
      end
   endtask

   // Response side: check transfers, then stall at random or hold off
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            check_response();
         end
         if (hold_cycles > 0) begin
            hold_cycles = hold_cycles - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   // Offer one request, wait for its transfer, then record what it should give
   task automatic send_request(input mm_request_t rq, input bit fixed = 1'b0,
                               input mm_response_t fixed_rsp = '0);
      mm_response_t predicted;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.func  <= rq.func;
      req_if.row   <= rq.row;
      req_if.col   <= rq.col;
      req_if.value <= rq.value;
      @(posedge clock);
      while (!req_if.ready) begin
         @(posedge clock);
      end
      predicted = matrix_response(rq);
      pending_products.push_back(fixed ? fixed_rsp : predicted);
      phase_count++;
   endtask

   // Drop valid and wait until every pending product has come back
   task automatic wait_for_drain(input int settle);
      req_if.valid <= 1'b0;
      while (pending_products.size() != 0) begin
         @(posedge clock);
      end
      repeat (settle) @(posedge clock);
   endtask

   // Leave the write enable high; the caller lowers it after the last write
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      case (idx)
         REG_ROWS_A: dim_rows_a = data;
         REG_COLS_A: dim_cols_a = data;
         REG_ROWS_B: dim_rows_b = data;
         REG_COLS_B: dim_cols_b = data;
         default:    ;
      endcase
   endtask

   task automatic program_dims(input logic [CFG_W-1:0] ra, input logic [CFG_W-1:0] ca,
                               input logic [CFG_W-1:0] rb, input logic [CFG_W-1:0] cb);
      wait_for_drain(SETTLE);
      write_csr(REG_ROWS_A, ra);
      write_csr(REG_COLS_A, ca);
      write_csr(REG_ROWS_B, rb);
      write_csr(REG_COLS_B, cb);
      csr_write_enable <= 1'b0;
   endtask

   // Write every operand a good read would use that has not been written yet
   task automatic fill_operands(input int r, input int c);
      mm_request_t wr;
      if (dim_cols_a == dim_rows_b && r < clamp_dim(dim_rows_a) && c < clamp_dim(dim_cols_b))
      begin
         for (int k = 0; k < clamp_dim(dim_cols_a); k++) begin
            if (!a_written[store_addr(r, k)]) begin
               wr = '{FUNC_WRITE_A, IDX_W'(r), IDX_W'(k), random_element()};
               send_request(wr);
            end
            if (!b_written[store_addr(k, c)]) begin
               wr = '{FUNC_WRITE_B, IDX_W'(k), IDX_W'(c), random_element()};
               send_request(wr);
            end
         end
      end
   endtask

   // Mostly in-range writes and reads; the rest is random noise
   task automatic send_random_item();
      mm_request_t rq;
      int          pick;
      pick     = $urandom_range(99);
      rq.func  = FUNC_W'($urandom_range(3));
      rq.row   = IDX_W'($urandom);
      rq.col   = IDX_W'($urandom);
      rq.value = random_element();
      if (pick < 35 && clamp_dim(dim_rows_a) > 0 && clamp_dim(dim_cols_a) > 0) begin
         rq.func = FUNC_WRITE_A;
         rq.row  = IDX_W'($urandom_range(clamp_dim(dim_rows_a) - 1));
         rq.col  = IDX_W'($urandom_range(clamp_dim(dim_cols_a) - 1));
      end else if (pick < 60 && clamp_dim(dim_rows_b) > 0 && clamp_dim(dim_cols_b) > 0) begin
         rq.func = FUNC_WRITE_B;
         rq.row  = IDX_W'($urandom_range(clamp_dim(dim_rows_b) - 1));
         rq.col  = IDX_W'($urandom_range(clamp_dim(dim_cols_b) - 1));
      end else if (pick < 90 && clamp_dim(dim_rows_a) > 0 && clamp_dim(dim_cols_b) > 0) begin
         rq.func = FUNC_READ;
         rq.row  = IDX_W'($urandom_range(clamp_dim(dim_rows_a) - 1));
         rq.col  = IDX_W'($urandom_range(clamp_dim(dim_cols_b) - 1));
      end
      if (rq.func == FUNC_READ) begin
         fill_operands(int'(rq.row), int'(rq.col));
      end
      send_request(rq);
   endtask

   initial begin
      logic [CFG_W-1:0] ra;
      logic [CFG_W-1:0] ca;
      logic [CFG_W-1:0] rb;
      logic [CFG_W-1:0] cb;
      bit               csr_open;
      bit               paused;

      // Hold every input at a known value through reset
      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.func        = FUNC_WRITE_A;
      req_if.row         = '0;
      req_if.col         = '0;
      req_if.value       = '0;
      rsp_if.ready       = 1'b0;
      csr_write_enable   = 1'b0;
      csr_index          = REG_ROWS_A;
      csr_write_data     = '0;
      dim_rows_a         = CFG_RESET;
      dim_cols_a         = CFG_RESET;
      dim_rows_b         = CFG_RESET;
      dim_cols_b         = CFG_RESET;
      error_count        = 0;
      phase_count        = 0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      hold_cycles        = 0;
      csr_open           = 1'b0;
      paused             = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Walk the directed table; register writes only once the block is idle
      foreach (directed_steps[i]) begin
         if (directed_steps[i].kind == STEP_CSR) begin
            if (!csr_open) begin
               wait_for_drain(SETTLE);
            end
            write_csr(directed_steps[i].reg_index, directed_steps[i].reg_data);
            csr_open = 1'b1;
         end else begin
            if (csr_open) begin
               csr_write_enable <= 1'b0;
               csr_open = 1'b0;
            end
            send_request(directed_steps[i].request, directed_steps[i].kind == STEP_SEND_FIXED,
                         directed_steps[i].response);
         end
      end

      // Random phases, each with its own sizes and idling pattern
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0: program_dims(6'd32, 6'd32, 6'd32, 6'd32);
            1: program_dims(6'd63, 6'd63, 6'd63, 6'd40);
            2: program_dims(6'd0, 6'd0, 6'd0, 6'd0);
            3: program_dims(6'd5, 6'd0, 6'd0, 6'd7);
            4: program_dims(6'd3, 6'd4, 6'd5, 6'd2);
            default: begin
               ra = ($urandom_range(9) == 0) ? CFG_W'($urandom_range(63, 33))
                                             : CFG_W'($urandom_range(6, 1));
               ca = CFG_W'($urandom_range(6, 1));
               rb = ($urandom_range(4) == 0) ? CFG_W'($urandom_range(8)) : ca;
               cb = ($urandom_range(9) == 0) ? CFG_W'($urandom_range(63, 33))
                                             : CFG_W'($urandom_range(6, 1));
               program_dims(ra, ca, rb, cb);
            end
         endcase
         case (phase % 4)
            0: begin sender_idle_pct = 0;          receiver_stall_pct = 0;          end
            1: begin sender_idle_pct = IDLE_HEAVY; receiver_stall_pct = 0;          end
            2: begin sender_idle_pct = 0;          receiver_stall_pct = IDLE_HEAVY; end
            default: begin sender_idle_pct = IDLE_BOTH; receiver_stall_pct = IDLE_BOTH; end
         endcase
         // Back up the response side while requests keep coming
         if (phase == HOLD_PHASE) begin
            hold_cycles = LONG_HOLD;
         end
         phase_count = 0;
         paused      = 1'b0;
         while (phase_count < PHASE_ITEMS) begin
            if (phase == PAUSE_PHASE && !paused && phase_count >= PHASE_ITEMS / 2) begin
               wait_for_drain(0);
               paused = 1'b1;
            end
            send_random_item();
         end
      end

      wait_for_drain(DRAIN_CYCLES);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Stop a hung run
   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule
